// ===== rtl/fsmi_pkg.sv =====
package fsmi_pkg;

    // Search limits
    localparam int MAX_PATTERN   = 16;
    localparam int POSITION_BITS = 16;
    localparam int WINDOW_DEPTH  = 16;
    localparam int LEN_CAP       = (MAX_PATTERN < WINDOW_DEPTH) ? MAX_PATTERN : WINDOW_DEPTH;
    localparam int LEN_BITS      = 5;
    localparam int WIN_IDX_BITS  = $clog2(WINDOW_DEPTH);
    localparam int INDEX_BITS    = 16;

    // Queue between front and back
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LEN  = 2'd2;

    // One classified text byte handed from front to back
    typedef struct packed {
        logic                     last;
        logic                     saturated;
        logic                     match;
        logic [POSITION_BITS-1:0] start;
    } item_t;

endpackage

// ===== rtl/fsmi_front.sv =====
module fsmi_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration writes
    input  logic                                 cfg_valid,
    input  logic [fsmi_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [63:0]                          cfg_data,
    // Text bytes
    input  logic                                 in_valid,
    input  logic [7:0]                           in_byte,
    input  logic                                 in_last,
    output logic                                 in_ready,
    // Classified item to the queue
    output logic                                 push,
    output fsmi_pkg::item_t                      push_item,
    input  logic                                 queue_full
);

    logic [63:0]                           pat_low_reg;
    logic [63:0]                           pat_high_reg;
    logic [fsmi_pkg::LEN_BITS-1:0]         pat_len_reg;
    logic [7:0]                            win_reg [fsmi_pkg::WINDOW_DEPTH];
    logic [7:0]                            win_next [fsmi_pkg::WINDOW_DEPTH];
    logic [fsmi_pkg::POSITION_BITS:0]      pos_reg;
    logic [fsmi_pkg::POSITION_BITS:0]      pos_next;
    logic [7:0]                            pat_bytes [16];
    logic [fsmi_pkg::LEN_BITS-1:0]         len_use;
    logic [fsmi_pkg::LEN_BITS-1:0]         pidx;
    logic [fsmi_pkg::WINDOW_DEPTH-1:0]     eq;
    logic [fsmi_pkg::POSITION_BITS:0]      pos_plus;
    logic                                  saturated;
    logic                                  in_text;
    logic                                  accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fsmi_pkg::REG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                fsmi_pkg::REG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                fsmi_pkg::REG_PATTERN_LEN:  pat_len_reg  <= cfg_data[fsmi_pkg::LEN_BITS-1:0];
                default:                    ;
            endcase
        end
    end

    // Unpack pattern bytes and clamp the length
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            pat_bytes[k]     = pat_low_reg[8*k +: 8];
            pat_bytes[k + 8] = pat_high_reg[8*k +: 8];
        end
        len_use = (pat_len_reg > fsmi_pkg::LEN_BITS'(fsmi_pkg::LEN_CAP))
                  ? fsmi_pkg::LEN_BITS'(fsmi_pkg::LEN_CAP) : pat_len_reg;
    end

    // Shift the window, newest byte at position 0
    always_comb
    begin
        win_next[0] = in_byte;
        for (int j = 1; j < fsmi_pkg::WINDOW_DEPTH; j++)
        begin
            win_next[j] = win_reg[j-1];
        end
    end

    // Compare the window tail with the pattern, last pattern byte newest
    always_comb
    begin
        pidx = '0;
        for (int j = 0; j < fsmi_pkg::WINDOW_DEPTH; j++)
        begin
            pidx  = fsmi_pkg::LEN_BITS'(len_use - fsmi_pkg::LEN_BITS'(j) - 1'b1);
            eq[j] = (fsmi_pkg::LEN_BITS'(j) >= len_use) ||
                    (win_next[j] == pat_bytes[pidx[3:0]]);
        end
    end

    // Classify the byte
    assign saturated = pos_reg[fsmi_pkg::POSITION_BITS];
    assign pos_plus  = pos_reg + 1'b1;
    assign in_text   = (pos_plus >= (fsmi_pkg::POSITION_BITS+1)'(len_use));

    always_comb
    begin
        push_item.last      = in_last;
        push_item.saturated = saturated;
        push_item.match     = (len_use == '0) || (in_text && (&eq));
        push_item.start     = (len_use == '0) ? '0 :
                              fsmi_pkg::POSITION_BITS'(pos_plus -
                                  (fsmi_pkg::POSITION_BITS+1)'(len_use));
    end

    // Advance the saturating position, restart on the last byte
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (in_last)
            begin
                pos_next = '0;
            end
            else if (!saturated)
            begin
                pos_next = pos_plus;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // Hold the window; clear it between texts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < fsmi_pkg::WINDOW_DEPTH; j++)
            begin
                win_reg[j] <= '0;
            end
        end
        else if (accept)
        begin
            for (int j = 0; j < fsmi_pkg::WINDOW_DEPTH; j++)
            begin
                win_reg[j] <= in_last ? 8'd0 : win_next[j];
            end
        end
    end

endmodule

// ===== rtl/fsmi_fifo.sv =====
module fsmi_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fsmi_pkg::item_t  push_item,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output fsmi_pkg::item_t  head_item
);

    fsmi_pkg::item_t                 mem_reg [fsmi_pkg::QUEUE_DEPTH];
    logic [fsmi_pkg::QPTR_BITS-1:0]  wr_ptr_reg;
    logic [fsmi_pkg::QPTR_BITS-1:0]  rd_ptr_reg;
    logic [fsmi_pkg::QPTR_BITS:0]    count_reg;
    logic [fsmi_pkg::QPTR_BITS:0]    count_next;

    assign full       = (count_reg == (fsmi_pkg::QPTR_BITS+1)'(fsmi_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/fsmi_back.sv =====
module fsmi_back (
    input  logic                                clk,
    input  logic                                rst_n,
    // Classified items from the queue
    input  logic                                head_valid,
    input  fsmi_pkg::item_t                     head_item,
    output logic                                pop,
    // Results
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                out_found,
    output logic [fsmi_pkg::INDEX_BITS-1:0]     out_index,
    output logic                                out_overflow
);

    logic                                 held_reg;
    logic                                 held_next;
    logic [fsmi_pkg::POSITION_BITS-1:0]   idx_reg;
    logic [fsmi_pkg::POSITION_BITS-1:0]   idx_next;
    logic                                 ovf_reg;
    logic                                 ovf_next;
    logic                                 held_upd;
    logic [fsmi_pkg::POSITION_BITS-1:0]   idx_upd;
    logic                                 ovf_upd;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic                                 found_reg;
    logic [fsmi_pkg::INDEX_BITS-1:0]      index_reg;
    logic                                 overflow_reg;

    // Pop unless a last item meets a full output register
    assign pop = head_valid && (!head_item.last || !out_valid_reg || out_ready);

    // Apply one item to the held match
    always_comb
    begin
        held_upd = held_reg;
        idx_upd  = idx_reg;
        ovf_upd  = ovf_reg;
        if (!held_reg)
        begin
            if (head_item.saturated)
            begin
                ovf_upd = 1'b1;
            end
            else if (head_item.match)
            begin
                held_upd = 1'b1;
                idx_upd  = head_item.start;
            end
        end

        held_next = held_reg;
        idx_next  = idx_reg;
        ovf_next  = ovf_reg;
        if (pop)
        begin
            if (head_item.last)
            begin
                held_next = 1'b0;
                idx_next  = '0;
                ovf_next  = 1'b0;
            end
            else
            begin
                held_next = held_upd;
                idx_next  = idx_upd;
                ovf_next  = ovf_upd;
            end
        end

        out_valid_next = out_valid_reg && !out_ready;
        if (pop && head_item.last)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= 1'b0;
            idx_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            idx_reg       <= idx_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result register on the last byte
    always_ff @(posedge clk)
    begin
        if (pop && head_item.last)
        begin
            found_reg    <= held_upd;
            index_reg    <= held_upd ? fsmi_pkg::INDEX_BITS'(idx_upd) : '0;
            overflow_reg <= ovf_upd;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_found    = found_reg;
    assign out_index    = index_reg;
    assign out_overflow = overflow_reg;

    // A result waiting on the output must not be overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && pop) |-> !head_item.last)
        else $error("last item popped over a pending result");

    // A text that saturated before matching can never report a match
    a_found_excludes_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(found_reg && overflow_reg))
        else $error("result reports both found and overflow");

    // Held state never shows overflow together with a match
    a_held_excludes_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        !(held_reg && ovf_reg))
        else $error("match held after overflow");

    // A nonzero index comes only with a match
    a_index_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (index_reg != '0)) |-> found_reg)
        else $error("index reported without a match");

endmodule

// ===== rtl/first_substring_match_index.sv =====
// Finds the first full occurrence of a pattern of up to 16 bytes in a byte stream. Text
// enters one byte per transaction on the s_ side, the final byte marked by s_tlast; the
// pattern and its length are set through the cfg port, by the user only while the block
// is idle; the block does not enforce it. It takes one byte every cycle while its queue
// has room: the window compare is a single parallel stage, and a four-entry queue lets
// byte intake continue while a result waits on the m_ side. One result per text is
// registered when its last byte leaves the queue. found reports a match lying wholly
// inside the text, match_index its start, and overflow that the text ran past 65536
// positions first; an empty pattern matches at index 0.
module first_substring_match_index (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fsmi_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [63:0]                          cfg_data,
    // Text input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] text_byte
    input  logic                                 s_tlast,   // last_byte
    // Result output
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [23:0]                          m_tdata    // [0] found, [16:1] match_index,
                                                            // [17] overflow, [23:18] zero
);

    logic                               push;
    fsmi_pkg::item_t                    push_item;
    logic                               queue_full;
    logic                               pop;
    logic                               head_valid;
    fsmi_pkg::item_t                    head_item;
    logic                               out_found;
    logic [fsmi_pkg::INDEX_BITS-1:0]    out_index;
    logic                               out_overflow;

    assign cfg_ready = 1'b1;

    fsmi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .in_ready   (s_tready),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    fsmi_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    fsmi_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_found    (out_found),
        .out_index    (out_index),
        .out_overflow (out_overflow)
    );

    // Pack the result
    assign m_tdata = {6'd0, out_overflow, out_index, out_found};

endmodule

// ===== sim/first_substring_match_index_tb.sv =====
module first_substring_match_index_tb;

    // Register index with no register behind it
    localparam logic [fsmi_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
    localparam logic [fsmi_pkg::POSITION_BITS:0]  POS_LIMIT  =
        (fsmi_pkg::POSITION_BITS+1)'(1) << fsmi_pkg::POSITION_BITS;
    localparam logic [127:0]                      PAT_ABCD   = 128'h44434241;

    typedef struct {
        logic                            found;
        logic [fsmi_pkg::INDEX_BITS-1:0] index;
        logic                            overflow;
    } search_result_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [fsmi_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [63:0]                       cfg_data;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [7:0]                        s_tdata;   // [7:0] text_byte
    logic                              s_tlast;   // last_byte
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [23:0]                       m_tdata;   // [0] found, [16:1] match_index, [17] overflow

    // Search model: registers and per-text state
    logic [63:0]                      pat_low;
    logic [63:0]                      pat_high;
    logic [4:0]                       pat_len;
    logic [7:0]                       window [fsmi_pkg::WINDOW_DEPTH];
    logic [fsmi_pkg::POSITION_BITS:0] text_pos;
    logic                             match_seen;
    logic [fsmi_pkg::INDEX_BITS-1:0]  match_start;
    logic                             pos_overflow;

    search_result_t pending_results [$];
    logic [7:0]     text_buf [$];
    int             fail_count         = 0;
    int             bytes_sent         = 0;
    int             sender_idle_pct    = 0;
    int             receiver_stall_pct = 0;

    first_substring_match_index dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Abort a hung run
    initial
    begin
        #10_000_000;
        $display("FAIL first_substring_match_index");
        $finish;
    end

    function automatic logic [7:0] pattern_at(input int k);
        return (k < 8) ? pat_low[8*(k%8) +: 8] : pat_high[8*(k%8) +: 8];
    endfunction

    function automatic int pattern_in_use();
        return (pat_len > fsmi_pkg::LEN_CAP) ? fsmi_pkg::LEN_CAP : int'(pat_len);
    endfunction

    function automatic void clear_text();
        foreach (window[k])
            window[k] = 8'h00;
        text_pos     = '0;
        match_seen   = 1'b0;
        match_start  = '0;
        pos_overflow = 1'b0;
    endfunction

    // Advance the search by one accepted text byte; queue the result on the last byte
    function automatic void advance_search(input logic [7:0] text_char, input logic is_last);
        int                               len;
        logic [fsmi_pkg::POSITION_BITS:0] pos;
        logic                             hit;
        search_result_t                   res;
        len = pattern_in_use();
        pos = text_pos;
        for (int k = fsmi_pkg::WINDOW_DEPTH - 1; k > 0; k--)
            window[k] = window[k-1];
        window[0] = text_char;
        if (!match_seen)
        begin
            if (pos >= POS_LIMIT)
                pos_overflow = 1'b1;
            else if (len == 0)
            begin
                match_seen  = 1'b1;
                match_start = '0;
            end
            else if (pos + 1 >= len)
            begin
                hit = 1'b1;
                for (int k = 0; k < len; k++)
                    if (window[len-1-k] != pattern_at(k))
                        hit = 1'b0;
                if (hit)
                begin
                    match_seen  = 1'b1;
                    match_start = fsmi_pkg::INDEX_BITS'(pos + 1 - len);
                end
            end
        end
        text_pos = (pos >= POS_LIMIT) ? POS_LIMIT : (fsmi_pkg::POSITION_BITS+1)'(pos + 1);
        if (is_last)
        begin
            res.found    = match_seen;
            res.index    = match_seen ? match_start : '0;
            res.overflow = pos_overflow;
            pending_results.push_back(res);
            clear_text();
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Drive the receiver stall pattern
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : result_check
        search_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no expectation: m_tdata %0h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("found", 32'(want.found), 32'(m_tdata[0]));
                check_field("match_index", 32'(want.index), 32'(m_tdata[16:1]));
                check_field("overflow", 32'(want.overflow), 32'(m_tdata[17]));
                check_field("tdata padding", 32'd0, 32'(m_tdata[23:18]));
            end
        end
    end

    // Send one text byte; called and returning at a falling edge
    task automatic send_byte(input logic [7:0] text_char, input logic is_last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = text_char;
        s_tlast  = is_last;
        do
            @(posedge clk);
        while (!s_tready);
        advance_search(text_char, is_last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text();
        foreach (text_buf[i])
            send_byte(text_buf[i], i == text_buf.size() - 1);
    endtask

    // Hold off until every result is back and the pipeline has settled
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [fsmi_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [63:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            fsmi_pkg::REG_PATTERN_LOW:  pat_low  = value;
            fsmi_pkg::REG_PATTERN_HIGH: pat_high = value;
            fsmi_pkg::REG_PATTERN_LEN:  pat_len  = value[4:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Load a pattern; junk in the upper bits of the length word must be dropped
    task automatic set_pattern(input logic [127:0] pat, input int len);
        logic [63:0] len_word;
        wait_idle();
        len_word      = {$urandom(), $urandom()};
        len_word[4:0] = len[4:0];
        write_reg(fsmi_pkg::REG_PATTERN_LOW, pat[63:0]);
        write_reg(fsmi_pkg::REG_PATTERN_HIGH, pat[127:64]);
        write_reg(fsmi_pkg::REG_PATTERN_LEN, len_word);
    endtask

    task automatic test_empty_pattern();
        set_pattern({$urandom(), $urandom(), $urandom(), $urandom()}, 0);
        text_buf = '{8'h00};
        send_text();
        text_buf = '{8'hff, 8'h80, 8'h01};
        send_text();
    endtask

    task automatic test_full_length_extremes();
        set_pattern(128'h00ff_ff00_00ff_ff00_00ff_ff00_00ff_ff00, 16);
        // Match completes on the final byte
        text_buf.delete();
        for (int k = 0; k < 16; k++)
            text_buf.push_back(pattern_at(k));
        send_text();
        // Match after a short lead-in
        text_buf = '{8'hff, 8'hff, 8'h00};
        for (int k = 0; k < 16; k++)
            text_buf.push_back(pattern_at(k));
        text_buf.push_back(8'hff);
        send_text();
    endtask

    task automatic test_cut_prefix();
        set_pattern(PAT_ABCD, 4);
        // Pattern cut off by the end of the text after its first three bytes
        text_buf = '{8'h5a, 8'h41, 8'h42, 8'h43};
        send_text();
        // Two occurrences: the first one is held
        text_buf = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h41, 8'h42, 8'h43, 8'h44};
        send_text();
        // Matching bytes split across two texts never count
        text_buf = '{8'h41, 8'h42};
        send_text();
        text_buf = '{8'h43, 8'h44};
        send_text();
    endtask

    task automatic test_length_clamp();
        set_pattern({$urandom(), $urandom(), $urandom(), $urandom()}, 31);
        text_buf = '{8'h33};
        for (int k = 0; k < 16; k++)
            text_buf.push_back(pattern_at(k));
        send_text();
        set_pattern({$urandom(), $urandom(), $urandom(), $urandom()}, 17);
        text_buf.delete();
        for (int k = 0; k < 16; k++)
            text_buf.push_back(pattern_at(k));
        send_text();
    endtask

    task automatic test_unknown_register();
        set_pattern(PAT_ABCD, 4);
        write_reg(REG_UNUSED, {$urandom(), $urandom()});
        write_reg(REG_UNUSED, 64'hffff_ffff_ffff_ffff);
        text_buf = '{8'h41, 8'h41, 8'h42, 8'h43, 8'h44};
        send_text();
    endtask

    task automatic test_position_saturation();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        set_pattern(PAT_ABCD, 4);
        // Match ending on the last countable position, text runs on past saturation
        for (int i = 0; i < POS_LIMIT - 4; i++)
            send_byte(8'h00, 1'b0);
        for (int k = 0; k < 4; k++)
            send_byte(pattern_at(k), 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        // Match that arrives only after saturation is dropped
        for (int i = 0; i < POS_LIMIT; i++)
            send_byte(8'h00, 1'b0);
        for (int k = 0; k < 4; k++)
            send_byte(pattern_at(k), k == 3);
    endtask

    task automatic random_pattern();
        logic [127:0] pat;
        int           sel;
        int           len;
        sel = $urandom_range(99);
        if (sel < 5)
            len = 0;
        else if (sel < 80)
            len = $urandom_range(5, 1);
        else if (sel < 95)
            len = $urandom_range(16, 6);
        else
            len = $urandom_range(31, 17);
        for (int k = 0; k < 16; k++)
            pat[8*k +: 8] = ($urandom_range(99) < 75) ? 8'(8'h61 + $urandom_range(2))
                                                      : 8'($urandom_range(255));
        set_pattern(pat, len);
    endtask

    // Build a text: mostly with a planted pattern, some with a cut prefix, some noise
    task automatic random_text();
        int         n;
        int         len;
        int         mode;
        int         at;
        int         cut;
        logic [7:0] c;
        len  = pattern_in_use();
        mode = $urandom_range(99);
        n    = $urandom_range(24, 1);
        if (mode >= 15 && mode < 90 && n < len)
            n = len + $urandom_range(4);
        text_buf.delete();
        repeat (n)
        begin
            c = (mode < 15) ? 8'($urandom_range(255)) : 8'(8'h61 + $urandom_range(2));
            text_buf.push_back(c);
        end
        if (mode >= 15 && mode < 75 && len > 0)
        begin
            at = $urandom_range(n - len);
            for (int k = 0; k < len; k++)
                text_buf[at+k] = pattern_at(k);
        end
        else if (mode >= 75 && mode < 90 && len > 1)
        begin
            cut = $urandom_range(len - 1, 1);
            for (int k = 0; k < cut; k++)
                text_buf[n-cut+k] = pattern_at(k);
        end
    endtask

    task automatic test_random_texts(input int send_pct, input int stall_pct, input int quota);
        int first;
        int texts;
        wait_idle();
        sender_idle_pct    = send_pct;
        receiver_stall_pct = stall_pct;
        first = bytes_sent;
        texts = 0;
        while (bytes_sent - first < quota)
        begin
            if (texts % 4 == 0)
                random_pattern();
            random_text();
            send_text();
            texts++;
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        pat_low   = '0;
        pat_high  = '0;
        pat_len   = '0;
        clear_text();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_empty_pattern();
        test_full_length_extremes();
        test_cut_prefix();
        test_length_clamp();
        test_unknown_register();
        test_position_saturation();
        test_random_texts(0, 0, 190);
        test_random_texts(73, 0, 190);
        test_random_texts(0, 73, 190);
        test_random_texts(32, 32, 190);

        wait_idle();
        if (fail_count == 0)
            $display("PASS first_substring_match_index");
        else
            $display("FAIL first_substring_match_index");
        $finish;
    end

endmodule
